### hw/rtl/spibt_pkg.sv
// Package for the SPI byte transmitter.
// Holds the phase codes and the item and result types shared by the RTL files.
// No dependencies.
`default_nettype none

package spibt_pkg;

    localparam int unsigned PhaseW = 3;
    localparam int unsigned TickW  = 18;
    localparam int unsigned HalfW  = 16;

    localparam logic [PhaseW-1:0] PH_IDLE    = 3'd0;
    localparam logic [PhaseW-1:0] PH_SETUP   = 3'd1;
    localparam logic [PhaseW-1:0] PH_DATA    = 3'd2;
    localparam logic [PhaseW-1:0] PH_LASTCLK = 3'd3;
    localparam logic [PhaseW-1:0] PH_CLEAR   = 3'd4;
    localparam logic [PhaseW-1:0] PH_RELEASE = 3'd5;

    localparam logic [2:0] LAST_BIT = 3'd7;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SEND = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] tx_byte;
    } t_item;

    typedef struct packed {
        logic cs_n;
        logic sclk;
        logic mosi;
        logic busy_res;
        logic send_refused;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/spibt_in_stage.sv
// Input register of the SPI byte transmitter.
// Holds one accepted item until the engine takes it; uses spibt_pkg.
`default_nettype none

module spibt_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  spibt_pkg::t_item    i_item,
    output logic                o_valid,
    output spibt_pkg::t_item    o_item,
    input  wire                 i_take
);

    logic             r_valid;
    spibt_pkg::t_item r_item;
    logic             n_valid;

    // The register may refill in the same cycle that the engine takes its item.
    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) begin
            n_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/spibt_engine.sv
// Transfer sequencer and result register of the SPI byte transmitter.
// Updates the line state for one item per cycle while the result register has room; uses spibt_pkg.
`default_nettype none

module spibt_engine (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire [spibt_pkg::HalfW-1:0]       i_half_bit_ticks,
    input  wire                              i_valid,
    input  spibt_pkg::t_item                 i_item,
    output logic                             o_take,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output spibt_pkg::t_result               o_result
);

    logic [spibt_pkg::PhaseW-1:0] r_phase, n_phase;
    logic [2:0]                   r_bit_index, n_bit_index;
    logic [7:0]                   r_shift_byte, n_shift_byte;
    logic [spibt_pkg::TickW-1:0]  r_tick_count, n_tick_count;
    logic                         r_sclk, n_sclk;
    logic                         r_mosi, n_mosi;
    logic                         r_cs, n_cs;
    logic                         r_out_valid, n_out_valid;
    spibt_pkg::t_result           r_result, n_result;

    logic                         w_busy;
    logic                         w_busy_next;
    logic                         w_refused;
    logic [spibt_pkg::HalfW-1:0]  w_half;
    logic [spibt_pkg::TickW-1:0]  w_period;
    logic [spibt_pkg::TickW-1:0]  w_tick_inc;

    assign o_take      = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign w_busy = (r_phase >= spibt_pkg::PH_SETUP) && (r_phase <= spibt_pkg::PH_RELEASE);

    // A period of zero ticks behaves as one tick.
    assign w_half     = (i_half_bit_ticks == '0) ? spibt_pkg::HalfW'(1) : i_half_bit_ticks;
    assign w_period   = (r_phase == spibt_pkg::PH_SETUP) ? {w_half, 2'b00} : {2'b00, w_half};
    assign w_tick_inc = r_tick_count + spibt_pkg::TickW'(1);

    always_comb begin
        n_phase      = r_phase;
        n_bit_index  = r_bit_index;
        n_shift_byte = r_shift_byte;
        n_tick_count = r_tick_count;
        n_sclk       = r_sclk;
        n_mosi       = r_mosi;
        n_cs         = r_cs;
        w_refused    = 1'b0;

        if (i_item.func == spibt_pkg::FUNC_SEND) begin
            if (w_busy) begin
                w_refused = 1'b1;
            end else begin
                n_bit_index  = spibt_pkg::LAST_BIT;
                n_phase      = spibt_pkg::PH_SETUP;
                n_shift_byte = i_item.tx_byte;
                n_cs         = 1'b0;
                n_sclk       = 1'b0;
                n_tick_count = '0;
            end
        end else if (w_busy) begin
            n_tick_count = w_tick_inc;
            if (w_tick_inc >= w_period) begin
                n_tick_count = '0;
                unique case (r_phase)
                    spibt_pkg::PH_SETUP: begin
                        n_phase = spibt_pkg::PH_DATA;
                    end
                    spibt_pkg::PH_DATA: begin
                        // A low clock before the first bit still needs the bit driven first.
                        if (r_sclk || (r_bit_index == spibt_pkg::LAST_BIT)) begin
                            n_mosi = r_shift_byte[r_bit_index];
                            n_sclk = 1'b0;
                            if (r_bit_index != 3'd0) begin
                                n_bit_index = r_bit_index - 3'd1;
                            end else begin
                                n_phase = spibt_pkg::PH_LASTCLK;
                            end
                        end else begin
                            n_sclk = 1'b1;
                        end
                    end
                    spibt_pkg::PH_LASTCLK: begin
                        n_sclk  = 1'b1;
                        n_phase = spibt_pkg::PH_CLEAR;
                    end
                    spibt_pkg::PH_CLEAR: begin
                        n_sclk  = 1'b0;
                        n_mosi  = 1'b0;
                        n_phase = spibt_pkg::PH_RELEASE;
                    end
                    spibt_pkg::PH_RELEASE: begin
                        n_cs    = 1'b1;
                        n_phase = spibt_pkg::PH_IDLE;
                    end
                    default: begin
                        n_phase = spibt_pkg::PH_IDLE;
                    end
                endcase
            end
        end else begin
            n_phase = spibt_pkg::PH_IDLE;
        end

        w_busy_next = (n_phase >= spibt_pkg::PH_SETUP) && (n_phase <= spibt_pkg::PH_RELEASE);

        n_result.cs_n         = n_cs;
        n_result.sclk         = n_sclk;
        n_result.mosi         = n_mosi;
        n_result.busy_res     = w_busy_next;
        n_result.send_refused = w_refused;

        n_out_valid = r_out_valid;
        if (!r_out_valid || i_out_ready) begin
            n_out_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= spibt_pkg::PH_IDLE;
            r_bit_index  <= 3'd0;
            r_shift_byte <= 8'd0;
            r_tick_count <= '0;
            r_sclk       <= 1'b0;
            r_mosi       <= 1'b0;
            r_cs         <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_phase      <= n_phase;
                r_bit_index  <= n_bit_index;
                r_shift_byte <= n_shift_byte;
                r_tick_count <= n_tick_count;
                r_sclk       <= n_sclk;
                r_mosi       <= n_mosi;
                r_cs         <= n_cs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

    // A refused send leaves the transfer running, so its result must show busy.
    a_refused_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.send_refused) |-> r_result.busy_res)
        else $error("refused send reported while not busy");

    // The lines rest at select high, clock low and data low between transfers.
    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == spibt_pkg::PH_IDLE) |-> (r_cs && !r_sclk && !r_mosi))
        else $error("lines not at rest while idle");

    // Chip select stays asserted through setup, data, the closing clock and the clear phase.
    a_cs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == spibt_pkg::PH_SETUP) || (r_phase == spibt_pkg::PH_DATA) ||
         (r_phase == spibt_pkg::PH_LASTCLK) || (r_phase == spibt_pkg::PH_CLEAR)) |-> !r_cs)
        else $error("chip select released during a transfer");

    // The sequencer moves only when an item is taken.
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |=> $stable(r_phase) && $stable(r_tick_count))
        else $error("state changed without an item");

endmodule

`default_nettype wire

### hw/rtl/spi_byte_transmitter.sv
// Top level of the write-only SPI byte transmitter (mode 0, MSB first).
// Instantiates spibt_in_stage and spibt_engine; uses spibt_pkg.
//
// Each input transfer is either one base timer tick or a request to send a byte, and
// each yields one result with the chip select, clock and data levels after it. The block
// takes one item every clock cycle while no result is held back; each result passes
// through the input register and then the result register, and the input keeps
// flowing while a result waits as long as the input register has room. The
// half-bit period is written on the configuration channel, which is always ready; the
// setup wait after chip select falls is four half-bit periods. A send while a byte is
// still going out is dropped and flagged in its result.
`default_nettype none

module spi_byte_transmitter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_func,
    input  wire  [7:0]  i_tx_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_cs_n,
    output logic        o_sclk,
    output logic        o_mosi,
    output logic        o_busy_res,
    output logic        o_send_refused,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [15:0] i_cfg_half_bit_ticks
);

    logic [spibt_pkg::HalfW-1:0] r_half_bit_ticks;
    spibt_pkg::t_item            w_in_item;
    spibt_pkg::t_item            w_stage_item;
    logic                        w_stage_valid;
    logic                        w_take;
    spibt_pkg::t_result          w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit_ticks <= spibt_pkg::HalfW'(1);
        end else if (i_cfg_valid) begin
            r_half_bit_ticks <= i_cfg_half_bit_ticks;
        end
    end

    assign w_in_item.func    = i_func;
    assign w_in_item.tx_byte = i_tx_byte;

    spibt_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (w_in_item),
        .o_valid    (w_stage_valid),
        .o_item     (w_stage_item),
        .i_take     (w_take)
    );

    spibt_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_half_bit_ticks (r_half_bit_ticks),
        .i_valid          (w_stage_valid),
        .i_item           (w_stage_item),
        .o_take           (w_take),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result         (w_result)
    );

    assign o_cs_n         = w_result.cs_n;
    assign o_sclk         = w_result.sclk;
    assign o_mosi         = w_result.mosi;
    assign o_busy_res     = w_result.busy_res;
    assign o_send_refused = w_result.send_refused;

endmodule

`default_nettype wire

### bench/tb_spi_byte_transmitter.sv
// Self-checking testbench for spi_byte_transmitter: directed rows, then random ticks and sends.
// Line levels are predicted per accepted item and compared with every result transfer.
// Depends on spibt_pkg and the spi_byte_transmitter RTL.
`default_nettype none

module tb_spi_byte_transmitter;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned HoldCycles = 80;

    typedef struct {
        logic                  func;
        logic [7:0]            tx;
        int unsigned           reps;
        bit                    typed;
        spibt_pkg::t_result    want;
    } t_dir_row;

    localparam spibt_pkg::t_result LINES_IDLE = '{cs_n: 1'b1, sclk: 1'b0, mosi: 1'b0,
                                                 busy_res: 1'b0, send_refused: 1'b0};
    localparam spibt_pkg::t_result LINES_STARTED = '{cs_n: 1'b0, sclk: 1'b0, mosi: 1'b0,
                                                    busy_res: 1'b1, send_refused: 1'b0};
    localparam spibt_pkg::t_result LINES_REFUSED = '{cs_n: 1'b0, sclk: 1'b0, mosi: 1'b0,
                                                    busy_res: 1'b1, send_refused: 1'b1};

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_func;
    logic [7:0]  in_tx_byte;
    logic        out_ready;
    logic        cfg_valid;
    logic [15:0] cfg_half;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_cs_n;
    logic        o_sclk;
    logic        o_mosi;
    logic        o_busy_res;
    logic        o_send_refused;
    logic        o_cfg_ready;

    spi_byte_transmitter dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (in_func),
        .i_tx_byte           (in_tx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (out_ready),
        .o_cs_n              (o_cs_n),
        .o_sclk              (o_sclk),
        .o_mosi              (o_mosi),
        .o_busy_res          (o_busy_res),
        .o_send_refused      (o_send_refused),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_half_bit_ticks(cfg_half)
    );

    // Shadow copy of the transmitter state.
    logic [spibt_pkg::PhaseW-1:0] sh_phase;
    logic [2:0]                   sh_bit;
    logic [7:0]                   sh_byte;
    logic [spibt_pkg::TickW-1:0]  sh_ticks;
    logic                         sh_sclk;
    logic                         sh_mosi;
    logic                         sh_cs;
    logic [spibt_pkg::HalfW-1:0]  sh_half;

    spibt_pkg::t_result line_levels_q[$];
    int unsigned        n_mismatch;
    int unsigned        n_results;
    int unsigned        cycles;
    int unsigned        hold_left;
    bit                 hold_done;
    bit                 sender_gaps;
    t_dir_row           dir_rows[5];

    function automatic bit line_busy();
        return sh_phase >= spibt_pkg::PH_SETUP && sh_phase <= spibt_pkg::PH_RELEASE;
    endfunction

    function automatic spibt_pkg::t_result predict_lines(input logic f, input logic [7:0] b);
        spibt_pkg::t_result          r;
        logic [spibt_pkg::TickW-1:0] half;
        logic [spibt_pkg::TickW-1:0] period;
        r.send_refused = 1'b0;
        if (f == spibt_pkg::FUNC_SEND) begin
            if (line_busy()) begin
                r.send_refused = 1'b1;
            end else begin
                sh_bit   = spibt_pkg::LAST_BIT;
                sh_phase = spibt_pkg::PH_SETUP;
                sh_byte  = b;
                sh_cs    = 1'b0;
                sh_sclk  = 1'b0;
                sh_ticks = '0;
            end
        end else if (line_busy()) begin
            half     = (sh_half == '0) ? spibt_pkg::TickW'(1) : spibt_pkg::TickW'(sh_half);
            period   = (sh_phase == spibt_pkg::PH_SETUP) ? (half << 2) : half;
            sh_ticks = sh_ticks + 1'b1;
            if (sh_ticks >= period) begin
                sh_ticks = '0;
                case (sh_phase)
                    spibt_pkg::PH_SETUP: sh_phase = spibt_pkg::PH_DATA;
                    spibt_pkg::PH_DATA: begin
                        // Data changes with the clock low; the first bit needs no rising edge first.
                        if (sh_sclk || sh_bit == spibt_pkg::LAST_BIT) begin
                            sh_mosi = sh_byte[sh_bit];
                            sh_sclk = 1'b0;
                            if (sh_bit != 3'd0)
                                sh_bit = sh_bit - 1'b1;
                            else
                                sh_phase = spibt_pkg::PH_LASTCLK;
                        end else begin
                            sh_sclk = 1'b1;
                        end
                    end
                    spibt_pkg::PH_LASTCLK: begin
                        sh_sclk  = 1'b1;
                        sh_phase = spibt_pkg::PH_CLEAR;
                    end
                    spibt_pkg::PH_CLEAR: begin
                        sh_sclk  = 1'b0;
                        sh_mosi  = 1'b0;
                        sh_phase = spibt_pkg::PH_RELEASE;
                    end
                    spibt_pkg::PH_RELEASE: begin
                        sh_cs    = 1'b1;
                        sh_phase = spibt_pkg::PH_IDLE;
                    end
                    default: sh_phase = spibt_pkg::PH_IDLE;
                endcase
            end
        end else begin
            sh_phase = spibt_pkg::PH_IDLE;
        end
        r.cs_n     = sh_cs;
        r.sclk     = sh_sclk;
        r.mosi     = sh_mosi;
        r.busy_res = line_busy();
        return r;
    endfunction

    // Leaves valid high after the transfer so back-to-back items need no second assignment.
    task automatic offer_item(input logic f, input logic [7:0] b, input bit typed,
                              input spibt_pkg::t_result want);
        spibt_pkg::t_result lv;
        if (sender_gaps && $urandom_range(0, 99) < 19) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 19);
        end
        in_valid   <= 1'b1;
        in_func    <= f;
        in_tx_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        lv = predict_lines(f, b);
        line_levels_q.push_back(typed ? want : lv);
    endtask

    task automatic write_half_bit(input logic [spibt_pkg::HalfW-1:0] v);
        in_valid <= 1'b0;
        while (line_levels_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_half  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        sh_half = v;
    endtask

    task automatic offer_ticks(input int unsigned count);
        for (int unsigned k = 0; k < count; k++)
            offer_item(spibt_pkg::FUNC_TICK, 8'($urandom_range(0, 255)), 1'b0, LINES_IDLE);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check every accepted transfer, then pick the next ready level.
    always @(posedge i_clk) begin
        spibt_pkg::t_result got;
        spibt_pkg::t_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            got = '{cs_n: o_cs_n, sclk: o_sclk, mosi: o_mosi, busy_res: o_busy_res,
                    send_refused: o_send_refused};
            n_results++;
            if (line_levels_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("Unexpected result %0d: cs_n=%b sclk=%b mosi=%b busy=%b refused=%b",
                             n_results, got.cs_n, got.sclk, got.mosi, got.busy_res,
                             got.send_refused);
            end else begin
                want = line_levels_q.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("Mismatch at result %0d: expected %b actual %b %s",
                                 n_results, want, got, "(cs_n sclk mosi busy refused)");
                end
            end
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!hold_done && n_results >= 400) begin
            // One long stall so the pipeline fills up and back-pressures the sender.
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            out_ready <= 1'b0;
        end else if (n_results >= 700 && n_results < 900) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= 19);
        end
    end

    initial begin
        logic [spibt_pkg::HalfW-1:0] settings[5];
        logic                        f;
        n_mismatch  = 0;
        n_results   = 0;
        cycles      = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        sender_gaps = 1'b1;
        i_rst_n    <= 1'b0;
        in_valid   <= 1'b0;
        in_func    <= spibt_pkg::FUNC_TICK;
        in_tx_byte <= 8'h00;
        out_ready  <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_half   <= 16'd1;

        sh_phase = spibt_pkg::PH_IDLE;
        sh_bit   = 3'd0;
        sh_byte  = 8'h00;
        sh_ticks = '0;
        sh_sclk  = 1'b0;
        sh_mosi  = 1'b0;
        sh_cs    = 1'b1;
        sh_half  = 16'd1;

        // At the reset period a whole byte takes 22 ticks: 4 of setup, 15 data edges,
        // the last rising clock, the clear and the release.
        dir_rows = '{
            '{spibt_pkg::FUNC_TICK, 8'h00, 1,  1'b1, LINES_IDLE},
            '{spibt_pkg::FUNC_SEND, 8'hFF, 1,  1'b1, LINES_STARTED},
            '{spibt_pkg::FUNC_SEND, 8'h00, 1,  1'b1, LINES_REFUSED},
            '{spibt_pkg::FUNC_TICK, 8'h5A, 22, 1'b0, LINES_IDLE},
            '{spibt_pkg::FUNC_TICK, 8'hA5, 1,  1'b1, LINES_IDLE}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            for (int unsigned k = 0; k < dir_rows[r].reps; k++)
                offer_item(dir_rows[r].func, dir_rows[r].tx, dir_rows[r].typed,
                           dir_rows[r].want);

        // Widest period, then a zero period while the setup count is already past it.
        write_half_bit(16'hFFFF);
        offer_item(spibt_pkg::FUNC_SEND, 8'h3C, 1'b0, LINES_IDLE);
        offer_ticks(300);
        write_half_bit(16'h0000);
        offer_ticks(40);

        settings = '{16'd2, 16'd1, 16'd3, 16'd0, 16'd1};
        foreach (settings[s]) begin
            write_half_bit(settings[s]);
            sender_gaps = (s != 2);
            for (int unsigned k = 0; k < 155; k++) begin
                if (!line_busy())
                    f = ($urandom_range(0, 99) < 35) ? spibt_pkg::FUNC_SEND
                                                     : spibt_pkg::FUNC_TICK;
                else
                    f = ($urandom_range(0, 99) < 6) ? spibt_pkg::FUNC_SEND
                                                    : spibt_pkg::FUNC_TICK;
                offer_item(f, 8'($urandom_range(0, 255)), 1'b0, LINES_IDLE);
            end
        end

        in_valid <= 1'b0;
        while (line_levels_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/spibt_pkg.sv
hw/rtl/spibt_in_stage.sv
hw/rtl/spibt_engine.sv
hw/rtl/spi_byte_transmitter.sv
bench/tb_spi_byte_transmitter.sv
